[rtl/scm_pkg.sv]
// ----------------------------------------------------------------------------
// scm_pkg: shared types and constants for the sector cache clock manager
// Action and status codes, the controller-to-datapath command struct and the
// datapath status struct.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int MAX_RES   = 64;
    localparam int SLOT_W    = 6;
    localparam int PIN_W     = 8;
    localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

    localparam logic [1:0] ACT_ACQUIRE  = 2'd0;
    localparam logic [1:0] ACT_PREFETCH = 2'd1;
    localparam logic [1:0] ACT_RELEASE  = 2'd2;
    localparam logic [1:0] ACT_FLUSH    = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_FREE     = 3'd1;
    localparam logic [2:0] ST_EVICT    = 3'd2;
    localparam logic [2:0] ST_ALLPIN   = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_RELMISS  = 3'd5;
    localparam logic [2:0] ST_FLUSHWB  = 3'd6;
    localparam logic [2:0] ST_FLUSHNO  = 3'd7;

    // Datapath scan operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1; // search tag, also track lowest invalid
    localparam logic [2:0] OP_CLOCK  = 3'd2; // one clock lap step
    localparam logic [2:0] OP_FLUSH  = 3'd3; // flush scan step
    localparam logic [2:0] OP_START  = 3'd4; // clear scan trackers, load index

    typedef struct packed {
        logic [2:0] op;
        logic       start_at_hand;
    } dp_cmd_t;

    typedef struct packed {
        logic       scan_done;   // index wrapped through all slots
        logic       hit_found;
        logic       free_found;
        logic       victim_now;  // unused unpinned slot found in this lap
        logic       flush_emit;  // flush candidate at current index
    } dp_stat_t;

endpackage

[rtl/scm_if.sv]
// ----------------------------------------------------------------------------
// scm_in_if / scm_out_if: valid-ready channels
// Transaction channels for input items and result items.
// ----------------------------------------------------------------------------
interface scm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] sector;
    logic        mark_dirty;
    logic        include_pinned;
    modport source (output valid, action, sector, mark_dirty, include_pinned, input ready);
    modport sink   (input valid, action, sector, mark_dirty, include_pinned, output ready);
endinterface

interface scm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic        fetch_needed;
    logic        writeback_needed;
    logic [31:0] writeback_sector;
    logic        last;
    modport source (output valid, status, slot, fetch_needed, writeback_needed,
                    writeback_sector, last, input ready);
    modport sink   (input valid, status, slot, fetch_needed, writeback_needed,
                    writeback_sector, last, output ready);
endinterface

[rtl/sector_cache_clock_manager_top.sv]
// ----------------------------------------------------------------------------
// sector_cache_clock_manager_top: sector cache tag and clock replacement manager
// Tag lookup, free-slot fill, second-chance eviction, release and flush.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_ch   | in  | action, sector, mark_dirty, include_pinned
//  out_ch  | out | status, slot, fetch_needed, writeback_needed,
//          |     | writeback_sector, last
//
//  Acquire/prefetch/release: one slot-per-cycle lookup lap, then a decision and
//  a result step that waits for the output register; an acquire/prefetch full
//  miss adds a clock lap (start, steps until a victim or the lap end, decision).
//  Flush: one lap over the slots, then a final result; a writeback result found
//  while the previous one still sits in the output register stalls the lap.
//  One transaction in flight; in_ch.ready is high only between transactions.
//  Reset clears valid, used and dirty flops; tag and pin tables are unreset.
// ----------------------------------------------------------------------------
module sector_cache_clock_manager_top #(
    parameter int SLOTS = scm_pkg::SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    scm_in_if.sink    in_ch,
    scm_out_if.source out_ch
);
    localparam int IW = $clog2(SLOTS);

    // command and status between sequencer and datapath
    scm_pkg::dp_cmd_t  cmd;
    scm_pkg::dp_stat_t stat;
    logic [31:0]   sector, victim_sector, cur_sector;
    logic          incl, do_fill, fill_pin, do_pin, do_release, rel_dirty;
    logic          do_flush_clr, use_victim, victim_ok, victim_dirty;
    logic [IW-1:0] res_idx, victim_idx, cur_idx;

    scm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk, .rst_n, .in_ch, .out_ch, .cmd, .sector, .incl, .do_fill,
        .fill_pin, .do_pin, .do_release, .rel_dirty, .do_flush_clr,
        .use_victim, .stat, .res_idx, .victim_idx, .victim_ok,
        .victim_dirty, .victim_sector, .cur_idx, .cur_sector
    );

    scm_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk, .rst_n, .cmd, .sector, .incl, .do_fill, .fill_pin, .do_pin,
        .do_release, .rel_dirty, .do_flush_clr, .use_victim, .stat,
        .res_idx, .victim_idx, .victim_ok, .victim_dirty, .victim_sector,
        .cur_idx, .cur_sector
    );

endmodule

[rtl/scm_datapath.sv]
// ----------------------------------------------------------------------------
// scm_datapath: slot state and scan datapath
// Holds per-slot state, steps a scan index one slot per cycle while a scan
// operation is commanded, and applies the updates selected by the controller.
// ----------------------------------------------------------------------------
module scm_datapath #(
    parameter int SLOTS = scm_pkg::SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scm_pkg::dp_cmd_t     cmd,
    input  logic [31:0]          sector,
    input  logic                 incl,
    input  logic                 do_fill,      // fill slot res_idx with sector
    input  logic                 fill_pin,
    input  logic                 do_pin,       // hit on acquire
    input  logic                 do_release,
    input  logic                 rel_dirty,
    input  logic                 do_flush_clr, // clear dirty at index
    input  logic                 use_victim,   // fill at clock victim choice
    output scm_pkg::dp_stat_t    stat,
    output logic [$clog2(SLOTS)-1:0] res_idx,  // hit or free slot
    output logic [$clog2(SLOTS)-1:0] victim_idx,
    output logic                 victim_ok,
    output logic                 victim_dirty,
    output logic [31:0]          victim_sector,
    output logic [$clog2(SLOTS)-1:0] cur_idx,
    output logic [31:0]          cur_sector
);
    localparam int IW = $clog2(SLOTS);
    localparam int PW = scm_pkg::PIN_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [PW-1:0] PIN_ONE  = PW'(1);

    logic [SLOTS-1:0] valid_reg, used_reg, dirty_reg;
    // tag and pin tables: only read for valid slots, so left unreset
    logic [PW-1:0] pins_mem [SLOTS];
    logic [31:0]   sector_mem [SLOTS];
    // registered read port, addressed with the next scan index
    logic [31:0]   rd_sector_reg;
    logic [PW-1:0] rd_pins_reg;

    logic [IW-1:0] idx_reg, cnt_reg, hand_reg;
    logic          cnt_wrap_reg;
    logic          hit_reg, free_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [PW-1:0] hit_pins_reg;
    logic          clean_v_reg, dirty_v_reg;
    logic [IW-1:0] clean_i_reg, dirty_i_reg;
    logic [31:0]   dirty_sec_reg;
    logic          now_reg;
    logic [IW-1:0] now_i_reg;
    logic [31:0]   now_sec_reg;

    logic [IW-1:0] fill_idx;
    logic          cur_valid, cur_used, cur_dirty, cur_unpinned;
    logic [IW-1:0] idx_inc, idx_next;
    logic          pin_we;
    logic [PW-1:0] pin_wdata;

    assign cur_valid    = valid_reg[idx_reg];
    assign cur_used     = used_reg[idx_reg];
    assign cur_dirty    = dirty_reg[idx_reg];
    assign cur_unpinned = (rd_pins_reg == '0);
    assign cur_sector   = rd_sector_reg;
    assign cur_idx      = idx_reg;
    assign idx_inc      = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign res_idx    = hit_reg ? hit_idx_reg : free_idx_reg;
    assign victim_ok  = now_reg | clean_v_reg | dirty_v_reg;
    assign victim_idx = now_reg ? now_i_reg : (clean_v_reg ? clean_i_reg : dirty_i_reg);
    assign victim_dirty  = dirty_reg[victim_idx];
    assign victim_sector = now_reg ? now_sec_reg : dirty_sec_reg;
    assign fill_idx   = use_victim ? victim_idx : free_idx_reg;

    assign stat.scan_done  = cnt_wrap_reg;
    assign stat.hit_found  = hit_reg;
    assign stat.free_found = free_reg;
    assign stat.victim_now = now_reg;
    assign stat.flush_emit = cur_valid && cur_dirty && (incl || cur_unpinned);

    always_comb
    begin
        case (cmd.op)
            scm_pkg::OP_START:  idx_next = cmd.start_at_hand ? hand_reg : '0;
            scm_pkg::OP_LOOKUP,
            scm_pkg::OP_CLOCK,
            scm_pkg::OP_FLUSH:  idx_next = idx_inc;
            default:            idx_next = idx_reg;
        endcase
    end

    // pin count update for the hit slot, saturating both ways
    always_comb
    begin
        pin_we    = 1'b0;
        pin_wdata = hit_pins_reg;
        if (do_pin && hit_pins_reg != scm_pkg::PIN_MAX)
        begin
            pin_we    = 1'b1;
            pin_wdata = hit_pins_reg + 1'b1;
        end
        else if (do_release && hit_pins_reg != '0)
        begin
            pin_we    = 1'b1;
            pin_wdata = hit_pins_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_sector_reg <= sector_mem[idx_next];
        rd_pins_reg   <= pins_mem[idx_next];
        if (do_fill)
        begin
            sector_mem[fill_idx] <= sector;
            pins_mem[fill_idx]   <= fill_pin ? PIN_ONE : '0;
        end
        else if (pin_we)
            pins_mem[hit_idx_reg] <= pin_wdata;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
            used_reg  <= '0;
            dirty_reg <= '0;
            idx_reg <= '0; cnt_reg <= '0; hand_reg <= '0; cnt_wrap_reg <= 1'b0;
            hit_reg <= 1'b0; free_reg <= 1'b0; now_reg <= 1'b0;
            clean_v_reg <= 1'b0; dirty_v_reg <= 1'b0;
            hit_idx_reg <= '0; free_idx_reg <= '0; now_i_reg <= '0;
            clean_i_reg <= '0; dirty_i_reg <= '0;
            hit_pins_reg <= '0; now_sec_reg <= '0; dirty_sec_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            case (cmd.op)
                scm_pkg::OP_START:
                begin
                    cnt_reg <= '0; cnt_wrap_reg <= 1'b0;
                    hit_reg <= 1'b0; free_reg <= 1'b0; now_reg <= 1'b0;
                    clean_v_reg <= 1'b0; dirty_v_reg <= 1'b0;
                end
                scm_pkg::OP_LOOKUP:
                begin
                    if (cur_valid && cur_sector == sector && !hit_reg) begin
                        hit_reg <= 1'b1; hit_idx_reg <= idx_reg;
                        hit_pins_reg <= rd_pins_reg;
                    end
                    if (!cur_valid && !free_reg) begin
                        free_reg <= 1'b1; free_idx_reg <= idx_reg;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    cnt_wrap_reg <= (cnt_reg == LAST_IDX);
                end
                scm_pkg::OP_CLOCK:
                begin
                    if (cur_valid && !now_reg) begin
                        if (cur_used) begin
                            used_reg[idx_reg] <= 1'b0;
                            if (cur_unpinned && cur_dirty && !dirty_v_reg) begin
                                dirty_v_reg <= 1'b1; dirty_i_reg <= idx_reg;
                                dirty_sec_reg <= rd_sector_reg;
                            end
                            if (cur_unpinned && !cur_dirty && !clean_v_reg) begin
                                clean_v_reg <= 1'b1; clean_i_reg <= idx_reg;
                            end
                        end else if (cur_unpinned) begin
                            now_reg <= 1'b1; now_i_reg <= idx_reg;
                            now_sec_reg <= rd_sector_reg;
                            hand_reg <= idx_reg;
                        end
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    cnt_wrap_reg <= (cnt_reg == LAST_IDX);
                end
                scm_pkg::OP_FLUSH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    cnt_wrap_reg <= (cnt_reg == LAST_IDX);
                end
                default:
                begin
                end
            endcase
            if (do_flush_clr)
                dirty_reg[idx_reg] <= 1'b0;
            if (do_fill) begin
                valid_reg[fill_idx] <= 1'b1;
                used_reg[fill_idx]  <= 1'b1;
                dirty_reg[fill_idx] <= 1'b0;
            end
            if (do_release) begin
                used_reg[hit_idx_reg] <= 1'b1;
                if (rel_dirty)
                    dirty_reg[hit_idx_reg] <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_excl: assert property (@(posedge clk) disable iff (!rst_n)
        do_fill |-> !do_pin && !do_release && !do_flush_clr)
        else $error("fill overlaps another update");
    a_victim_used: assert property (@(posedge clk) disable iff (!rst_n)
        (do_fill && use_victim) |-> victim_ok)
        else $error("eviction without victim");
    a_pin_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pin || do_release) |-> hit_reg)
        else $error("pin update without hit");
`endif

endmodule

[rtl/scm_ctrl.sv]
// ----------------------------------------------------------------------------
// scm_ctrl: transaction sequencer
// Accepts one input transaction, steers the datapath scans and drives the
// registered result stage.
// ----------------------------------------------------------------------------
module scm_ctrl #(
    parameter int SLOTS = scm_pkg::SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    scm_in_if.sink             in_ch,
    scm_out_if.source          out_ch,
    output scm_pkg::dp_cmd_t   cmd,
    output logic [31:0]        sector,
    output logic               incl,
    output logic               do_fill,
    output logic               fill_pin,
    output logic               do_pin,
    output logic               do_release,
    output logic               rel_dirty,
    output logic               do_flush_clr,
    output logic               use_victim,
    input  scm_pkg::dp_stat_t  stat,
    input  logic [$clog2(SLOTS)-1:0] res_idx,
    input  logic [$clog2(SLOTS)-1:0] victim_idx,
    input  logic               victim_ok,
    input  logic               victim_dirty,
    input  logic [31:0]        victim_sector,
    input  logic [$clog2(SLOTS)-1:0] cur_idx,
    input  logic [31:0]        cur_sector
);
    localparam int CW = $clog2(scm_pkg::MAX_RES + 1);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_CLKST  = 3'd2;
    localparam logic [2:0] S_CLOCK  = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [2:0] S_FWAIT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  act_reg;
    logic [31:0] sec_reg;
    logic        md_reg, incl_reg;
    logic [CW-1:0] n_reg;

    // pending (held) flush result, emitted when next one or the end is known
    logic        pend_reg;
    logic [5:0]  pend_slot_reg;
    logic [31:0] pend_sec_reg;

    logic        ov_reg;
    logic [2:0]  o_st_reg;
    logic [5:0]  o_sl_reg;
    logic        o_f_reg, o_wb_reg, o_last_reg;
    logic [31:0] o_ws_reg;

    logic        out_free, emit;
    logic [2:0]  e_st;
    logic [5:0]  e_sl;
    logic        e_f, e_wb, e_last;
    logic [31:0] e_ws;
    logic        is_load, flush_take, flush_end;

    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign sector = sec_reg;
    assign incl   = incl_reg;
    assign rel_dirty = md_reg;
    assign fill_pin  = (act_reg == scm_pkg::ACT_ACQUIRE);
    assign is_load   = (act_reg == scm_pkg::ACT_ACQUIRE) || (act_reg == scm_pkg::ACT_PREFETCH);

    assign out_ch.valid = ov_reg;
    assign out_ch.status = o_st_reg;
    assign out_ch.slot = o_sl_reg;
    assign out_ch.fetch_needed = o_f_reg;
    assign out_ch.writeback_needed = o_wb_reg;
    assign out_ch.writeback_sector = o_ws_reg;
    assign out_ch.last = o_last_reg;

    // flush: a candidate is taken when the output can take the held one
    assign flush_take = (state_reg == S_FLUSH) && !stat.scan_done && stat.flush_emit
                        && n_reg != CW'(scm_pkg::MAX_RES) && (!pend_reg || out_free);
    assign flush_end  = (state_reg == S_FLUSH)
                        && (stat.scan_done || n_reg == CW'(scm_pkg::MAX_RES));

    always_comb begin
        cmd = '{op: scm_pkg::OP_NONE, start_at_hand: 1'b0};
        state_next = state_reg;
        do_fill = 1'b0; do_pin = 1'b0; do_release = 1'b0;
        do_flush_clr = 1'b0; use_victim = 1'b0;
        emit = 1'b0;
        e_st = scm_pkg::ST_HIT; e_sl = '0; e_f = 1'b0; e_wb = 1'b0; e_ws = '0; e_last = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid) begin
                    cmd.op = scm_pkg::OP_START;
                    state_next = (in_ch.action == scm_pkg::ACT_FLUSH) ? S_FLUSH : S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!stat.scan_done) begin
                    cmd.op = scm_pkg::OP_LOOKUP;
                end else if (!is_load) begin
                    state_next = S_OUT;
                end else if (stat.hit_found || stat.free_found) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_CLKST;
                end
            end
            S_CLKST:
            begin
                cmd = '{op: scm_pkg::OP_START, start_at_hand: 1'b1};
                state_next = S_CLOCK;
            end
            S_CLOCK:
            begin
                if (!stat.scan_done && !stat.victim_now)
                    cmd.op = scm_pkg::OP_CLOCK;
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free) begin
                    emit = 1'b1;
                    state_next = S_IDLE;
                    if (act_reg == scm_pkg::ACT_RELEASE) begin
                        if (stat.hit_found) begin
                            do_release = 1'b1;
                            e_st = scm_pkg::ST_RELEASED;
                            e_sl = 6'(res_idx);
                        end else begin
                            e_st = scm_pkg::ST_RELMISS;
                        end
                    end else if (stat.hit_found) begin
                        do_pin = fill_pin;
                        e_st = scm_pkg::ST_HIT;
                        e_sl = 6'(res_idx);
                    end else if (stat.free_found) begin
                        do_fill = 1'b1;
                        e_st = scm_pkg::ST_FREE;
                        e_sl = 6'(res_idx);
                        e_f = 1'b1;
                    end else if (victim_ok) begin
                        do_fill = 1'b1;
                        use_victim = 1'b1;
                        e_st = scm_pkg::ST_EVICT;
                        e_sl = 6'(victim_idx);
                        e_f = 1'b1;
                        e_wb = victim_dirty;
                        e_ws = victim_dirty ? victim_sector : '0;
                    end else begin
                        e_st = scm_pkg::ST_ALLPIN;
                    end
                end
            end
            S_FLUSH:
            begin
                if (flush_end) begin
                    state_next = S_FWAIT;
                end else if (!stat.flush_emit || flush_take) begin
                    cmd.op = scm_pkg::OP_FLUSH;
                    do_flush_clr = flush_take;
                    emit = flush_take && pend_reg;
                    e_st = scm_pkg::ST_FLUSHWB; e_sl = pend_slot_reg;
                    e_wb = 1'b1; e_ws = pend_sec_reg; e_last = 1'b0;
                end
            end
            S_FWAIT:
            begin
                if (out_free) begin
                    emit = 1'b1;
                    state_next = S_IDLE;
                    if (pend_reg) begin
                        e_st = scm_pkg::ST_FLUSHWB; e_sl = pend_slot_reg;
                        e_wb = 1'b1; e_ws = pend_sec_reg;
                    end else begin
                        e_st = scm_pkg::ST_FLUSHNO;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                pend_reg <= 1'b0;
                n_reg <= '0;
            end else if (flush_take) begin
                pend_reg <= 1'b1;
                n_reg <= n_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) begin
            act_reg  <= in_ch.action;
            sec_reg  <= in_ch.sector;
            md_reg   <= in_ch.mark_dirty;
            incl_reg <= in_ch.include_pinned;
        end
        if (flush_take) begin
            pend_slot_reg <= 6'(cur_idx);
            pend_sec_reg  <= cur_sector;
        end
        if (emit) begin
            o_st_reg <= e_st; o_sl_reg <= e_sl; o_f_reg <= e_f;
            o_wb_reg <= e_wb; o_ws_reg <= e_ws; o_last_reg <= e_last;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> $stable(o_st_reg) && $stable(o_ws_reg))
        else $error("result overwritten while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("second transaction accepted while busy");
    a_flush_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CW'(scm_pkg::MAX_RES))
        else $error("flush count overflow");
`endif

endmodule
